>>> src/alm_pkg.sv
`default_nettype none

package alm_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAIN = 2'd2;

  // register reset values
  localparam logic [9:0] NOISE_FLOOR_RST  = 10'd16;
  localparam logic [7:0] ATTACK_GAIN_RST  = 8'd128;
  localparam logic [7:0] RELEASE_GAIN_RST = 8'd64;

  // fixed field widths
  localparam int SAMPLE_IN_W = 10;
  localparam int SPAN_OUT_W  = 10;
  localparam int LEVEL_W     = 8;

  // divisors of the peak decay and the smoothing step
  localparam int PEAK_DECAY_DIV = 48;
  localparam int LEVEL_FULL     = 255;

endpackage

`default_nettype wire

>>> src/alm_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module alm_div #(
  parameter int DW = 19,
  parameter int VW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dsr_q;

  logic [VW:0]   rem_shift;
  logic [VW:0]   rem_diff;
  logic          fits;

  // one trial subtraction
  always_comb begin
    rem_shift = {rem_q, quo_q[DW-1]};
    rem_diff  = rem_shift - {1'b0, dsr_q};
    fits      = rem_shift >= {1'b0, dsr_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_diff[VW-1:0] : rem_shift[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> src/audio_level_meter_top.sv
// per-frame level meter: a sample that does not close its frame leaves in_ready_o high
// a closing sample runs one scaling division on the divider (PW = max(SAMPLE_BITS + 1, 11)),
// stepping through peak update, scale, divider wait, multiply, step and done; the division
// is skipped when the span is at or below the floor
// in_ready_o stays low until the result is loaded, longer while the last one waits
// async active-low reset: registers at their defaults, frame and peak cleared
`default_nettype none

module audio_level_meter_top #(
  parameter int FRAME_SAMPLES = 64,
  parameter int SAMPLE_BITS   = 10
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [alm_pkg::SAMPLE_IN_W-1:0]     sample_i,
  input  wire logic                                frame_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [alm_pkg::LEVEL_W-1:0]              level_o,
  output logic [alm_pkg::SPAN_OUT_W-1:0]           span_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [alm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [alm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import alm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = (SB + 1 > 11) ? SB + 1 : 11;
  localparam int DW = PW + 8;
  localparam int CW = $clog2(FRAME_SAMPLES);
  localparam logic [CW-1:0] CNT_LAST = CW'(FRAME_SAMPLES - 1);
  // peak / 48 as ((peak >> 4) * 683) >> 11, exact for the peak range
  localparam int DECAY_W     = PW + 6;
  localparam int THIRD_RECIP = 683;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_PEAK_UPD   = 3'd1;
  localparam logic [2:0] ST_SCALE      = 3'd2;
  localparam logic [2:0] ST_SCALE_WAIT = 3'd3;
  localparam logic [2:0] ST_MUL        = 3'd4;
  localparam logic [2:0] ST_STEP       = 3'd5;
  localparam logic [2:0] ST_DONE       = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [9:0]         nf_q;
  logic [7:0]         attack_q;
  logic [7:0]         release_q;
  logic [SB-1:0]      min_q;
  logic [SB-1:0]      max_q;
  logic [CW-1:0]      cnt_q;
  logic [PW-1:0]      peak_q;
  logic [PW-1:0]      span_q;
  logic [7:0]         target_q;
  logic [7:0]         lvl_q;
  logic [7:0]         lvl_next_q;
  logic               down_q;
  logic [15:0]        prod_q;
  logic               out_valid_q;
  logic [SPAN_OUT_W-1:0] span_out_q;

  logic [SB-1:0]      smp;
  logic [SB-1:0]      min_n;
  logic [SB-1:0]      max_n;
  logic               in_acc;
  logic               closes;
  logic [PW-1:0]      nf;
  logic [PW-1:0]      floor2;
  logic [DECAY_W-1:0] decay_prod;
  logic [PW-1:0]      decay;
  logic [PW-1:0]      peak_pre;
  logic               above_nf;
  logic [DW-1:0]      excess;
  logic               up;
  logic [7:0]         mag;
  logic [7:0]         gain;
  logic [15:0]        prod;
  logic [15:0]        step_sum;
  logic [7:0]         step;
  logic               out_load;

  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [PW-1:0]      div_divisor;
  logic               div_done;
  logic [DW-1:0]      div_quo;

  alm_div #(
    .DW(DW),
    .VW(PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // per-sample min/max and frame close
  always_comb begin
    smp    = SB'(sample_i);
    min_n  = (smp < min_q) ? smp : min_q;
    max_n  = (smp > max_q) ? smp : max_q;
    in_acc = in_valid_i && in_ready_o;
    closes = frame_end_i || (cnt_q == CNT_LAST);
  end

  // frame-end arithmetic around the divider
  always_comb begin
    nf         = PW'(nf_q);
    floor2     = PW'({nf_q, 1'b0});
    decay_prod = DECAY_W'(peak_q[PW-1:4]) * DECAY_W'(THIRD_RECIP);
    decay      = PW'(decay_prod >> 11);
    peak_pre   = (span_q > peak_q) ? span_q : (peak_q - decay);
    above_nf   = span_q > nf;
    excess     = DW'(span_q - nf);
    up         = target_q > lvl_q;
    mag        = up ? (target_q - lvl_q) : (lvl_q - target_q);
    gain       = up ? attack_q : release_q;
    prod       = mag * gain;
    // product / 255, truncated, exact for an 8 by 8 bit product
    step_sum   = prod_q + {8'd0, prod_q[15:8]} + 16'd1;
    step       = step_sum[15:8];
    out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  // divider operands: span excess times 255 over peak above the floor
  always_comb begin
    div_start    = (state_q == ST_SCALE) && above_nf;
    div_dividend = (excess << 8) - excess;
    div_divisor  = (peak_q > nf) ? (peak_q - nf) : PW'(1);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_acc && closes) state_d = ST_PEAK_UPD;
      ST_PEAK_UPD:   state_d = ST_SCALE;
      ST_SCALE:      state_d = above_nf ? ST_SCALE_WAIT : ST_MUL;
      ST_SCALE_WAIT: if (div_done) state_d = ST_MUL;
      ST_MUL:        state_d = ST_STEP;
      ST_STEP:       state_d = ST_DONE;
      ST_DONE:       if (out_load) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nf_q        <= NOISE_FLOOR_RST;
      attack_q    <= ATTACK_GAIN_RST;
      release_q   <= RELEASE_GAIN_RST;
      min_q       <= '1;
      max_q       <= '0;
      cnt_q       <= '0;
      peak_q      <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_NOISE_FLOOR:  nf_q      <= cfg_data_i[9:0];
          REG_ATTACK_GAIN:  attack_q  <= cfg_data_i[7:0];
          REG_RELEASE_GAIN: release_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end

      // frame tracking
      if (in_acc) begin
        if (closes) begin
          min_q <= '1;
          max_q <= '0;
          cnt_q <= '0;
        end else begin
          min_q <= min_n;
          max_q <= max_n;
          cnt_q <= cnt_q + 1'b1;
        end
      end

      // peak decay and floor
      if (state_q == ST_PEAK_UPD) begin
        peak_q <= (peak_pre < floor2) ? floor2 : peak_pre;
      end

      // result hand-off
      if (out_load) begin
        lvl_q       <= lvl_next_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && closes) begin
      span_q <= PW'(max_n - min_n);
    end
    if (state_q == ST_SCALE && !above_nf) begin
      target_q <= '0;
    end
    if (state_q == ST_SCALE_WAIT && div_done) begin
      target_q <= (|div_quo[DW-1:8]) ? 8'hFF : div_quo[7:0];
    end
    if (state_q == ST_MUL) begin
      down_q <= !up;
      prod_q <= prod;
    end
    if (state_q == ST_STEP) begin
      lvl_next_q <= down_q ? (lvl_q - step) : (lvl_q + step);
    end
    if (out_load) begin
      span_out_q <= SPAN_OUT_W'(span_q);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign level_o     = lvl_q;
  assign span_o      = span_out_q;

endmodule

`default_nettype wire

>>> src/alm_checker.sv
`default_nettype none

module alm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           frame_end_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [alm_pkg::LEVEL_W-1:0]    level_o,
  input wire logic [alm_pkg::SPAN_OUT_W-1:0] span_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(level_o) && $stable(span_o))
    else $error("result payload changed while stalled");

  // a frame end always starts the busy computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && frame_end_i |=> !in_ready_o)
    else $error("ready right after a frame end");

  // a new result only comes out of the busy computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind audio_level_meter_top alm_checker u_alm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .frame_end_i (frame_end_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .level_o     (level_o),
  .span_o      (span_o)
);

`default_nettype wire
